// ===== hdl/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

    // Result kind reported with every transfer on the output stream.
    typedef enum logic [1:0] {
        KIND_ROM_READ   = 2'd0,
        KIND_RAM_READ   = 2'd1,
        KIND_WRITE      = 2'd2,
        KIND_READ_ERROR = 2'd3
    } t_access_kind;

    // Bus access direction carried on the input stream.
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // 8 KB bus regions, selected by address bits 15:13.
    typedef logic [2:0] t_region;
    localparam t_region REGION_RAM_ENABLE = 3'd0;  // 0x0000-0x1FFF
    localparam t_region REGION_ROM_BANK   = 3'd1;  // 0x2000-0x3FFF
    localparam t_region REGION_RAM_BANK   = 3'd2;  // 0x4000-0x5FFF
    localparam t_region REGION_CART_RAM   = 3'd5;  // 0xA000-0xBFFF

    localparam int BANK_OFFSET_BITS = 13;  // 8 KB RAM bank
    localparam int ROM_OFFSET_BITS  = 14;  // 16 KB ROM bank
    localparam int ROM_ADDR_BITS    = 19;

    localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
    localparam logic [7:0] ROM_BANK_MASK  = 8'h1F;
    localparam logic [7:0] RAM_BANK_MASK  = 8'h03;

endpackage

`default_nettype wire

// ===== hdl/cartridge_bank_mapper_top.sv =====
// Top level of the cartridge bank mapper: bus access decode, bank registers and cartridge RAM.
// Each result passes through the first stage and then the output register before it leaves.
// Throughput: one access per cycle while the output is not stalled, set by the single-port RAM and two stages.
// After reset the cartridge RAM is zeroed one byte per cycle, all RAM_BANKS * 8192 bytes
// (32768 with the default), and no input transfer is taken until that pass ends.
// Reset also disables RAM, selects ROM bank 1 and RAM bank 0, and empties both stages.
`default_nettype none

module cartridge_bank_mapper_top #(
    parameter int ROM_BANK_BITS = 5,
    parameter int RAM_BANKS     = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [15:0] bus_address, [23:16] write_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] mode

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [18:0] rom_address, [26:19] read_byte, rest 0
    output logic [1:0]       m_axis_tuser    // [1:0] access_kind
);
    import cbm_pkg::*;

    // Cartridge RAM geometry. The bank index field is at least one bit wide so that a
    // single-bank cartridge still has a legal register; the address cast drops it then.
    localparam int RAM_DEPTH = RAM_BANKS * (1 << BANK_OFFSET_BITS);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int BANK_W    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;

    // Input fields.
    logic        in_mode;
    logic [15:0] in_addr;
    logic [7:0]  in_byte;
    logic        accept;

    assign in_mode = s_axis_tuser[0];
    assign in_addr = s_axis_tdata[15:0];
    assign in_byte = s_axis_tdata[23:16];
    assign accept  = s_axis_tvalid && s_axis_tready;

    // Mapper state.
    logic                     r_ram_en;
    logic [ROM_BANK_BITS-1:0] r_rom_bank;
    logic [BANK_W-1:0]        r_ram_bank;   // already reduced modulo RAM_BANKS
    logic                     n_ram_en;
    logic [ROM_BANK_BITS-1:0] n_rom_bank;
    logic [BANK_W-1:0]        n_ram_bank;

    // Cartridge RAM and its clearing sweep.
    logic [7:0]        mem [RAM_DEPTH];
    logic              r_clr_active;
    logic [RAM_AW-1:0] r_clr_addr;

    // First stage: decode result plus the registered RAM read data.
    logic                     r_a_valid;
    t_access_kind             r_a_kind;
    logic [ROM_ADDR_BITS-1:0] r_a_rom_addr;
    logic [7:0]               r_a_rd_data;

    // Output stage.
    logic                     r_o_valid;
    t_access_kind             r_o_kind;
    logic [ROM_ADDR_BITS-1:0] r_o_rom_addr;
    logic [7:0]               r_o_byte;

    logic a_advance;

    // Decode outputs.
    t_access_kind             dec_kind;
    logic [ROM_ADDR_BITS-1:0] dec_rom_addr;
    logic                     dec_ram_wr;
    logic [RAM_AW-1:0]        ram_idx;
    t_region                  region;
    logic [4:0]               bank_mod;
    logic [ROM_BANK_BITS-1:0] rom_bank_wr;

    assign region  = in_addr[15:13];
    assign ram_idx = RAM_AW'({r_ram_bank, in_addr[BANK_OFFSET_BITS-1:0]});

    // A result in the first stage moves on whenever the output register is free or
    // being emptied; a new transfer is taken whenever the first stage will be free.
    assign a_advance     = r_a_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_active && (!r_a_valid || a_advance);

    // Reduce the written RAM bank modulo RAM_BANKS. The value is below four, so
    // three conditional subtractions always finish the reduction.
    always_comb begin
        bank_mod = 5'(in_byte & RAM_BANK_MASK);
        for (int k = 0; k < 3; k++) begin
            if (bank_mod >= 5'(RAM_BANKS)) begin
                bank_mod = bank_mod - 5'(RAM_BANKS);
            end
        end
    end

    // The ROM bank written is masked to five bits and to the bank register width.
    // Bank zero cannot be selected for the switchable window and reads as bank one.
    always_comb begin
        rom_bank_wr = ROM_BANK_BITS'(in_byte & ROM_BANK_MASK);
        if (rom_bank_wr == '0) begin
            rom_bank_wr = ROM_BANK_BITS'(1);
        end
    end

    always_comb begin
        dec_kind     = KIND_READ_ERROR;
        dec_rom_addr = '0;
        dec_ram_wr   = 1'b0;
        n_ram_en     = r_ram_en;
        n_rom_bank   = r_rom_bank;
        n_ram_bank   = r_ram_bank;
        if (in_mode == MODE_WRITE) begin
            dec_kind = KIND_WRITE;
            unique case (region)
                REGION_RAM_ENABLE: n_ram_en = ((in_byte & RAM_ENABLE_KEY) == RAM_ENABLE_KEY);
                REGION_ROM_BANK:   n_rom_bank = rom_bank_wr;
                REGION_RAM_BANK: begin
                    if (r_ram_en) begin
                        n_ram_bank = BANK_W'(bank_mod);
                    end
                end
                REGION_CART_RAM:   dec_ram_wr = r_ram_en;
                default: ;  // writes elsewhere change nothing
            endcase
        end else begin
            if (!in_addr[15] && !in_addr[14]) begin
                // Fixed bank zero window.
                dec_kind     = KIND_ROM_READ;
                dec_rom_addr = ROM_ADDR_BITS'(in_addr);
            end else if (!in_addr[15]) begin
                // Switchable window: bank number above the 16 KB offset.
                dec_kind     = KIND_ROM_READ;
                dec_rom_addr = ROM_ADDR_BITS'({r_rom_bank, in_addr[ROM_OFFSET_BITS-1:0]});
            end else if (region == REGION_CART_RAM && r_ram_en) begin
                dec_kind = KIND_RAM_READ;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en     <= 1'b0;
            r_rom_bank   <= ROM_BANK_BITS'(1);
            r_ram_bank   <= '0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_a_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_ram_en   <= n_ram_en;
                r_rom_bank <= n_rom_bank;
                r_ram_bank <= n_ram_bank;
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + RAM_AW'(1);
                if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (a_advance) begin
                r_a_valid <= 1'b0;
            end
            if (a_advance) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Cartridge RAM: one port, written by the clearing sweep or by an accepted
    // RAM write, read with a registered output on every accepted transfer.
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            mem[r_clr_addr] <= 8'h00;
        end else if (accept && dec_ram_wr) begin
            mem[ram_idx] <= in_byte;
        end
        if (accept) begin
            r_a_rd_data <= mem[ram_idx];
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_kind     <= dec_kind;
            r_a_rom_addr <= dec_rom_addr;
        end
        if (a_advance) begin
            r_o_kind     <= r_a_kind;
            r_o_rom_addr <= r_a_rom_addr;
            r_o_byte     <= (r_a_kind == KIND_RAM_READ) ? r_a_rd_data : 8'h00;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = 32'({r_o_byte, r_o_rom_addr});
    assign m_axis_tuser  = r_o_kind;

    // No transfer is taken while the RAM is being cleared.
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !s_axis_tready)
        else $error("input transfer possible during RAM clearing");

    // The switchable ROM bank never holds bank zero.
    a_rom_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank != '0)
        else $error("ROM bank register holds zero");

    // Only ROM reads carry a ROM address, only RAM reads carry a data byte.
    a_rom_addr_only_on_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind != KIND_ROM_READ) |-> (r_o_rom_addr == '0))
        else $error("ROM address on a non-ROM result");

    a_byte_only_on_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind != KIND_RAM_READ) |-> (r_o_byte == 8'h00))
        else $error("read byte on a non-RAM result");

    // A result held in the first stage is not lost while the output stalls.
    a_stage_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_o_valid && !m_axis_tready) |=> r_a_valid)
        else $error("first stage dropped a result during output stall");

endmodule

`default_nettype wire
